### hdl/mbc1_pkg.sv
// Shared types and constants for the MBC1 bank mapper.
`default_nettype none

package mbc1_pkg;

  typedef enum logic [2:0] {
    ACT_OPEN   = 3'd0,
    ACT_ROM    = 3'd1,
    ACT_RAM_RD = 3'd2,
    ACT_RAM_WR = 3'd3,
    ACT_ABSORB = 3'd4
  } action_t;

  localparam logic [1:0] CFG_ROM_BANK_BITS = 2'd0;
  localparam logic [1:0] CFG_RAM_BANK_BITS = 2'd1;
  localparam logic [1:0] CFG_RAM_BYTES     = 2'd2;
  localparam logic [1:0] CFG_RAM_PRESENT   = 2'd3;

  localparam logic [1:0] REG_RAM_ENABLE = 2'd0;
  localparam logic [1:0] REG_LOW_BANK   = 2'd1;
  localparam logic [1:0] REG_HIGH_BANK  = 2'd2;
  localparam logic [1:0] REG_MODE       = 2'd3;

  localparam logic [2:0] RAM_WINDOW_TAG = 3'b101;
  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

  localparam int ROM_BANK_BITS_W = 3;
  localparam int RAM_BANK_BITS_W = 2;
  localparam int RAM_BYTES_W     = 16;

  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    action_t     action;
    logic [20:0] mapped_address;
    logic [7:0]  ram_write_data;
  } out_item_t;

  typedef struct packed {
    logic        ram_enable;
    logic [6:0]  upper_rom_bank;
    logic [6:0]  lower_window_bank;
    logic [1:0]  ram_bank_select;
    logic [15:0] ram_bytes;
  } map_ctx_t;

endpackage

`default_nettype wire

### hdl/mbc1_bank_mapper_unit.sv
// Top level of the MBC1 bank mapper: request and result registers around the mapping logic.
//
// The in_ channel carries one bus request (op, address, write_data) with in_valid and
// in_stall; the out_ channel returns one result (action, mapped_address, ram_write_data)
// per request, in order, with out_valid and out_stall. The cfg_ channel writes the four
// configuration registers by index and is always ready; the user must see that it is written
// only while idle, as the block itself does not enforce this. A request taken is held in the
// request register, mapped there against the current bank state, and its result is loaded
// into the result register once that register is free. Throughput is one request per cycle
// while out_stall is low, set by the single mapping stage between the request and result
// registers. Bank register writes take effect for the very next request. While out_stall
// holds a result, one more request is held in the request register, after which in_stall
// rises. The synchronous reset loads the configuration defaults, disables RAM, selects
// bank 1 in mode 0 and empties both registers.
`default_nettype none

module mbc1_bank_mapper_unit
  import mbc1_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output out_item_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [RAM_BYTES_W-1:0] cfg_data
);

  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_free;
  logic      s1_fire;
  logic      in_accept;
  map_ctx_t  ctx;
  out_item_t result;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mbc1_bank_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .upd_en    (s1_fire),
    .item      (s1_data_r),
    .ctx       (ctx)
  );

  mbc1_access_map u_map (
    .item   (s1_data_r),
    .ctx    (ctx),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= result;
    end
  end

  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("A mapped request did not reach the result register.");

  a_stall_needs_held_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("Input stalled without a held request.");

  a_wdata_only_on_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.action != ACT_RAM_WR) |-> out_data_r.ram_write_data == 8'd0)
    else $error("Write data present on a result that is not a RAM write.");

  a_no_address_when_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.action == ACT_OPEN || out_data_r.action == ACT_ABSORB))
      |-> out_data_r.mapped_address == 21'd0)
    else $error("Open bus or absorbed result carries an address.");

endmodule

`default_nettype wire

### hdl/mbc1_bank_regs.sv
// Configuration and bank registers with the derived bank selections.
`default_nettype none

module mbc1_bank_regs
  import mbc1_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [RAM_BYTES_W-1:0]     cfg_data,
  input  wire logic                       upd_en,
  input  wire in_item_t                   item,
  output map_ctx_t                        ctx
);

  logic [ROM_BANK_BITS_W-1:0] rom_bank_bits_r;
  logic [RAM_BANK_BITS_W-1:0] ram_bank_bits_r;
  logic [RAM_BYTES_W-1:0]     ram_bytes_r;
  logic                       ram_present_r;
  logic                       ram_enable_r;
  logic [4:0]                 low_bank_r;
  logic [1:0]                 high_bank_r;
  logic                       mode_r;
  logic                       reg_write;
  logic [6:0]                 rmask;
  logic [1:0]                 amask;
  logic [6:0]                 high_shifted;

  assign reg_write = upd_en && item.op && !item.address[15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_bits_r <= 3'd7;
      ram_bank_bits_r <= 2'd2;
      ram_bytes_r     <= 16'd32768;
      ram_present_r   <= 1'b1;
      ram_enable_r    <= 1'b0;
      low_bank_r      <= 5'd1;
      high_bank_r     <= 2'd0;
      mode_r          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROM_BANK_BITS: rom_bank_bits_r <= cfg_data[ROM_BANK_BITS_W-1:0];
          CFG_RAM_BANK_BITS: ram_bank_bits_r <= cfg_data[RAM_BANK_BITS_W-1:0];
          CFG_RAM_BYTES:     ram_bytes_r     <= cfg_data;
          CFG_RAM_PRESENT:   ram_present_r   <= cfg_data[0];
          default:           ram_present_r   <= ram_present_r;
        endcase
      end
      if (reg_write) begin
        case (item.address[14:13])
          REG_RAM_ENABLE: begin
            ram_enable_r <= (item.write_data[3:0] == RAM_ENABLE_KEY) && ram_present_r;
          end
          REG_LOW_BANK: begin
            low_bank_r <= (item.write_data[4:0] == 5'd0) ? 5'd1 : item.write_data[4:0];
          end
          REG_HIGH_BANK: high_bank_r <= item.write_data[1:0];
          REG_MODE:      mode_r      <= item.write_data[0];
          default:       mode_r      <= mode_r;
        endcase
      end
    end
  end

  always_comb begin
    rmask        = 7'((8'd1 << rom_bank_bits_r) - 8'd1);
    amask        = 2'((3'd1 << ram_bank_bits_r) - 3'd1);
    high_shifted = {high_bank_r, 5'd0};
    ctx.ram_enable        = ram_enable_r;
    ctx.upper_rom_bank    = {high_bank_r, low_bank_r} & rmask;
    ctx.lower_window_bank = mode_r ? (high_shifted & rmask) : 7'd0;
    ctx.ram_bank_select   = mode_r ? (high_bank_r & amask) : 2'd0;
    ctx.ram_bytes         = ram_bytes_r;
  end

endmodule

`default_nettype wire

### hdl/mbc1_access_map.sv
// Address decode and bank mapping of one bus request.
`default_nettype none

module mbc1_access_map
  import mbc1_pkg::*;
(
  input  wire in_item_t  item,
  input  wire map_ctx_t  ctx,
  output out_item_t      result
);

  logic [14:0] ram_off;

  always_comb begin
    ram_off = {ctx.ram_bank_select, item.address[12:0]};
    result.action         = item.op ? ACT_ABSORB : ACT_OPEN;
    result.mapped_address = 21'd0;
    result.ram_write_data = 8'd0;
    if (item.address[15:13] == RAM_WINDOW_TAG) begin
      if (ctx.ram_enable && ({1'b0, ram_off} < ctx.ram_bytes)) begin
        result.mapped_address = {6'd0, ram_off};
        if (item.op) begin
          result.action         = ACT_RAM_WR;
          result.ram_write_data = item.write_data;
        end else begin
          result.action = ACT_RAM_RD;
        end
      end
    end else if (!item.op) begin
      case (item.address[15:14])
        2'b00: begin
          result.action         = ACT_ROM;
          result.mapped_address = {ctx.lower_window_bank, item.address[13:0]};
        end
        2'b01: begin
          result.action         = ACT_ROM;
          result.mapped_address = {ctx.upper_rom_bank, item.address[13:0]};
        end
        default: result.action = ACT_OPEN;
      endcase
    end
  end

endmodule

`default_nettype wire

### test/tb_mbc1_bank_mapper_unit.sv
// Self-checking testbench for the MBC1 bank mapper: directed table, random traffic, checks.
module tb_mbc1_bank_mapper_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mbc1_pkg::*;

  localparam int unsigned ROM_BANK_SIZE = 16384;
  localparam int unsigned RAM_BANK_SIZE = 8192;
  localparam int unsigned ROM_SPAN_MASK = 32'h1F_FFFF;
  localparam int          REPORT_LIMIT  = 10;

  typedef enum logic {ROW_ACCESS, ROW_SETTING} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    in_item_t    req;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    bit          typed;
    out_item_t   want;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predicted mapper state and configuration.
  logic [2:0]  rom_bits;
  logic [1:0]  ram_bits;
  logic [15:0] ram_limit;
  logic        ram_fitted;
  logic        ram_on;
  logic [4:0]  bank_lo;
  logic [1:0]  bank_hi;
  logic        mode;

  out_item_t   expected_results[$];
  stim_row_t   directed_rows[$];
  int          mismatches = 0;
  int          send_idle_pct = 19;
  int          rx_idle_pct = 77;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  mbc1_bank_mapper_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void reset_mapper();
    rom_bits   = 3'd7;
    ram_bits   = 2'd2;
    ram_limit  = 16'd32768;
    ram_fitted = 1'b1;
    ram_on     = 1'b0;
    bank_lo    = 5'd1;
    bank_hi    = 2'd0;
    mode       = 1'b0;
  endfunction

  function automatic void apply_setting(logic [1:0] idx, logic [15:0] value);
    case (idx)
      CFG_ROM_BANK_BITS: rom_bits = value[2:0];
      CFG_RAM_BANK_BITS: ram_bits = value[1:0];
      CFG_RAM_BYTES:     ram_limit = value;
      CFG_RAM_PRESENT:   ram_fitted = value[0];
      default: ;
    endcase
  endfunction

  function automatic out_item_t map_access(in_item_t r);
    out_item_t   res;
    int unsigned rmask;
    int unsigned amask;
    int unsigned upper;
    int unsigned rbank;
    int unsigned lower_off;
    int unsigned off;
    rmask     = (32'd1 << rom_bits) - 1;
    amask     = (32'd1 << ram_bits) - 1;
    upper     = ((32'(bank_hi) << 5) | 32'(bank_lo)) & rmask & 32'h7F;
    rbank     = mode ? (32'(bank_hi) & amask & 32'h3) : 0;
    lower_off = mode ? (((32'(bank_hi) << 5) & rmask) * ROM_BANK_SIZE) & ROM_SPAN_MASK : 0;
    res.action         = r.op ? ACT_ABSORB : ACT_OPEN;
    res.mapped_address = '0;
    res.ram_write_data = '0;
    if (r.address >= 16'hA000 && r.address < 16'hC000) begin
      off = (32'(r.address) - 32'hA000) + rbank * RAM_BANK_SIZE;
      if (ram_on && off < 32'(ram_limit)) begin
        res.mapped_address = 21'(off);
        if (r.op) begin
          res.action         = ACT_RAM_WR;
          res.ram_write_data = r.write_data;
        end else begin
          res.action = ACT_RAM_RD;
        end
      end
    end else if (r.op) begin
      if (r.address < 16'h2000) begin
        ram_on = (r.write_data[3:0] == RAM_ENABLE_KEY) && ram_fitted;
      end else if (r.address < 16'h4000) begin
        bank_lo = r.write_data[4:0];
        if (bank_lo == 5'd0) bank_lo = 5'd1;
      end else if (r.address < 16'h6000) begin
        bank_hi = r.write_data[1:0];
      end else if (r.address < 16'h8000) begin
        mode = r.write_data[0];
      end
    end else if (r.address < 16'h4000) begin
      res.action         = ACT_ROM;
      res.mapped_address = 21'((lower_off + 32'(r.address)) & ROM_SPAN_MASK);
    end else if (r.address < 16'h8000) begin
      res.action         = ACT_ROM;
      res.mapped_address =
        21'((32'(r.address) - 32'h4000 + upper * ROM_BANK_SIZE) & ROM_SPAN_MASK);
    end
    return res;
  endfunction

  function automatic in_item_t random_access();
    in_item_t r;
    int       pick;
    pick         = $urandom_range(0, 99);
    r.op         = 1'($urandom);
    r.address    = 16'($urandom);
    r.write_data = 8'($urandom);
    if (pick < 10) begin
      r.op      = 1'b1;
      r.address = 16'($urandom_range(32'h0000, 32'h1FFF));
      if ($urandom_range(0, 2) != 0) r.write_data[3:0] = RAM_ENABLE_KEY;
    end else if (pick < 20) begin
      r.op      = 1'b1;
      r.address = 16'($urandom_range(32'h2000, 32'h3FFF));
      if ($urandom_range(0, 3) == 0) r.write_data[4:0] = 5'd0;
    end else if (pick < 26) begin
      r.op      = 1'b1;
      r.address = 16'($urandom_range(32'h4000, 32'h5FFF));
    end else if (pick < 30) begin
      r.op      = 1'b1;
      r.address = 16'($urandom_range(32'h6000, 32'h7FFF));
    end else if (pick < 55) begin
      r.op      = 1'b0;
      r.address = 16'($urandom_range(32'h0000, 32'h7FFF));
    end else if (pick < 85) begin
      r.address = 16'($urandom_range(32'hA000, 32'hBFFF));
    end
    return r;
  endfunction

  task automatic add_req(logic op, logic [15:0] addr, logic [7:0] data);
    stim_row_t row;
    row.kind    = ROW_ACCESS;
    row.req     = '{op, addr, data};
    row.reg_idx = '0;
    row.reg_val = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_checked(logic op, logic [15:0] addr, logic [7:0] data,
                             action_t act, logic [20:0] maddr, logic [7:0] wdata);
    stim_row_t row;
    row.kind                = ROW_ACCESS;
    row.req                 = '{op, addr, data};
    row.reg_idx             = '0;
    row.reg_val             = '0;
    row.typed               = 1'b1;
    row.want.action         = act;
    row.want.mapped_address = maddr;
    row.want.ram_write_data = wdata;
    directed_rows.push_back(row);
  endtask

  task automatic add_setting(logic [1:0] idx, logic [15:0] value);
    stim_row_t row;
    row.kind    = ROW_SETTING;
    row.req     = '0;
    row.reg_idx = idx;
    row.reg_val = value;
    row.typed   = 1'b0;
    row.want    = '0;
    directed_rows.push_back(row);
  endtask

  task automatic send_req(in_item_t req, bit typed, out_item_t want);
    out_item_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    got = map_access(req);
    expected_results.push_back(typed ? want : got);
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(logic [1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_setting(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_valid && send_idle_pct == 0 && rx_idle_pct == 0) begin
      out_stall <= 1'b1;
      hold_left <= 60;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected result: action %0d address %h data %h",
                   out_data.action, out_data.mapped_address, out_data.ram_write_data);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_data.action !== want.action ||
            out_data.mapped_address !== want.mapped_address ||
            out_data.ram_write_data !== want.ram_write_data) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch: expected action %0d address %h data %h, got %0d %h %h",
                     want.action, want.mapped_address, want.ram_write_data,
                     out_data.action, out_data.mapped_address, out_data.ram_write_data);
          end
        end
      end
    end
  end

  initial begin
    logic [31:0] noise;
    logic [2:0]  rom_sel;
    logic [1:0]  ram_sel;
    logic [15:0] size_sel;
    logic        fitted_sel;
    int          n;

    reset_mapper();
    add_checked(1'b0, 16'h0000, 8'h00, ACT_ROM, 21'h000000, 8'h00);
    add_checked(1'b0, 16'h4000, 8'h00, ACT_ROM, 21'h004000, 8'h00);
    add_checked(1'b0, 16'h7FFF, 8'hFF, ACT_ROM, 21'h007FFF, 8'h00);
    add_checked(1'b0, 16'hA000, 8'h00, ACT_OPEN, 21'h0, 8'h00);
    add_checked(1'b1, 16'hA123, 8'h55, ACT_ABSORB, 21'h0, 8'h00);
    add_checked(1'b1, 16'h0000, 8'h0A, ACT_ABSORB, 21'h0, 8'h00);
    add_checked(1'b0, 16'hA000, 8'h00, ACT_RAM_RD, 21'h000000, 8'h00);
    add_checked(1'b1, 16'hBFFF, 8'hFF, ACT_RAM_WR, 21'h001FFF, 8'hFF);
    add_checked(1'b1, 16'h2000, 8'h00, ACT_ABSORB, 21'h0, 8'h00);
    add_checked(1'b0, 16'h4000, 8'h00, ACT_ROM, 21'h004000, 8'h00);
    add_req(1'b1, 16'h3FFF, 8'hFF);
    add_req(1'b1, 16'h5FFF, 8'h03);
    add_req(1'b0, 16'h7FFF, 8'h00);
    add_req(1'b1, 16'h6000, 8'h01);
    add_req(1'b0, 16'h0000, 8'h00);
    add_req(1'b0, 16'hBFFF, 8'h00);
    add_req(1'b1, 16'h2000, 8'h20);
    add_req(1'b0, 16'h4000, 8'h00);
    add_checked(1'b0, 16'h8000, 8'h00, ACT_OPEN, 21'h0, 8'h00);
    add_checked(1'b0, 16'hC000, 8'h00, ACT_OPEN, 21'h0, 8'h00);
    add_checked(1'b1, 16'hFFFF, 8'hAA, ACT_ABSORB, 21'h0, 8'h00);
    add_setting(CFG_ROM_BANK_BITS, 16'd0);
    add_req(1'b0, 16'h4000, 8'h00);
    add_setting(CFG_RAM_BANK_BITS, 16'd3);
    add_req(1'b0, 16'hA000, 8'h00);
    add_setting(CFG_RAM_PRESENT, 16'd0);
    add_req(1'b0, 16'hA000, 8'h00);
    add_checked(1'b1, 16'h1FFF, 8'h0A, ACT_ABSORB, 21'h0, 8'h00);
    add_checked(1'b0, 16'hA000, 8'h00, ACT_OPEN, 21'h0, 8'h00);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SETTING) begin
        settle();
        write_setting(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int seg = 0; seg < 7; seg++) begin
      settle();
      case (seg)
        0: begin rom_sel = 3'd7; ram_sel = 2'd2; size_sel = 16'd32768; fitted_sel = 1'b1; end
        1: begin rom_sel = 3'd0; ram_sel = 2'd0; size_sel = 16'd0;     fitted_sel = 1'b0; end
        2: begin rom_sel = 3'd1; ram_sel = 2'd3; size_sel = 16'hFFFF;  fitted_sel = 1'b1; end
        3: begin rom_sel = 3'd7; ram_sel = 2'd2; size_sel = 16'd0;     fitted_sel = 1'b1; end
        4: begin rom_sel = 3'd4; ram_sel = 2'd1; size_sel = 16'd16384; fitted_sel = 1'b1; end
        default: begin
          rom_sel    = 3'($urandom_range(0, 7));
          ram_sel    = 2'($urandom_range(0, 3));
          size_sel   = 16'($urandom);
          fitted_sel = ($urandom_range(0, 3) != 0);
        end
      endcase
      noise = $urandom;
      write_setting(CFG_ROM_BANK_BITS, {noise[15:3], rom_sel});
      write_setting(CFG_RAM_BANK_BITS, {noise[31:18], ram_sel});
      write_setting(CFG_RAM_BYTES, size_sel);
      write_setting(CFG_RAM_PRESENT, {noise[23:9], fitted_sel});
      for (int k = 0; k < 200; k++) begin
        n = seg * 200 + k;
        if (n < 470) begin
          send_idle_pct = 19;
          rx_idle_pct   = 77;
        end else if (n < 940) begin
          send_idle_pct = 77;
          rx_idle_pct   = 19;
        end else begin
          send_idle_pct = 0;
          rx_idle_pct   = 0;
        end
        send_req(random_access(), 1'b0, '0);
      end
    end

    settle();
    if (expected_results.size() != 0) mismatches += expected_results.size();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
